@@ sv/ife_pkg.sv @@
// Shared types, character codes and helper functions for the integer format engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ife_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int CAP_W                 = 16;
    localparam int OUT_POS_W             = 16;
    localparam logic [15:0] CAP_RESET    = 16'd256;

    // character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BAD   = 8'h9D;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CH_LC_D    = 8'h64;
    localparam logic [7:0] CH_LC_I    = 8'h69;
    localparam logic [7:0] CH_LC_U    = 8'h75;
    localparam logic [7:0] CH_LC_B    = 8'h62;
    localparam logic [7:0] CH_LC_O    = 8'h6F;
    localparam logic [7:0] CH_LC_X    = 8'h78;
    localparam logic [7:0] CH_UC_X    = 8'h58;

    // digit unit radix modes
    localparam logic [1:0] MODE_DEC = 2'd0;
    localparam logic [1:0] MODE_BIN = 2'd1;
    localparam logic [1:0] MODE_OCT = 2'd2;
    localparam logic [1:0] MODE_HEX = 2'd3;

    // digit unit operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_DABBLE = 2'd2;
    localparam logic [1:0] OP_SHIFT  = 2'd3;

    typedef struct packed {
        logic        command;
        logic [7:0]  format_char;
        logic [31:0] arg_value;
    } ife_in_t;

    typedef struct packed {
        logic [7:0]           out_char;
        logic [OUT_POS_W-1:0] out_position;
        logic                 stored;
        logic                 run_last;
        logic [OUT_POS_W-1:0] total_length;
    } ife_out_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  mode;
        logic        upper;
        logic [31:0] value;
    } ife_dcmd_t;

    typedef struct packed {
        logic [3:0] digit;
        logic       upper;
        logic       last_digit;
        logic       last_step;
    } ife_dstat_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last;
        logic       term;
    } ife_emit_t;

    function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            base = CHAR_ZERO;
        end else begin
            base = upper ? 8'd55 : 8'd87;
        end
        return base + {4'b0000, d};
    endfunction

endpackage

`default_nettype wire

@@ sv/ife_digit_unit.sv @@
// Shared digit unit: double-dabble binary to BCD and MSB-first digit shifter.
// Depends on ife_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ife_digit_unit (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  ife_pkg::ife_dcmd_t   cmd_i,
    output ife_pkg::ife_dstat_t  stat_o
);
    import ife_pkg::*;

    // digits sit left-aligned in work_reg, top digit at [39:...]
    logic [39:0] work_reg, work_next;
    logic [31:0] bin_reg, bin_next;
    logic [5:0]  step_reg, step_next;
    logic [5:0]  left_reg, left_next;
    logic [1:0]  mode_reg, mode_next;
    logic        upper_reg, upper_next;
    logic [39:0] adj;

    // add 3 to every BCD nibble of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            if (work_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = work_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = work_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        work_next  = work_reg;
        bin_next   = bin_reg;
        step_next  = step_reg;
        left_next  = left_reg;
        mode_next  = mode_reg;
        upper_next = upper_reg;
        unique case (cmd_i.op)
            OP_LOAD: begin
                mode_next  = cmd_i.mode;
                upper_next = cmd_i.upper;
                step_next  = 6'd32;
                bin_next   = cmd_i.value;
                case (cmd_i.mode)
                    MODE_DEC: begin
                        work_next = '0;
                        left_next = 6'd10;
                    end
                    MODE_BIN: begin
                        work_next = {cmd_i.value, 8'h00};
                        left_next = 6'd32;
                    end
                    MODE_OCT: begin
                        work_next = {1'b0, cmd_i.value, 7'h00};
                        left_next = 6'd11;
                    end
                    default: begin
                        work_next = {cmd_i.value, 8'h00};
                        left_next = 6'd8;
                    end
                endcase
            end
            OP_DABBLE: begin
                work_next = {adj[38:0], bin_reg[31]};
                bin_next  = {bin_reg[30:0], 1'b0};
                step_next = step_reg - 6'd1;
            end
            OP_SHIFT: begin
                left_next = left_reg - 6'd1;
                case (mode_reg)
                    MODE_BIN: work_next = {work_reg[38:0], 1'b0};
                    MODE_OCT: work_next = {work_reg[36:0], 3'b000};
                    default:  work_next = {work_reg[35:0], 4'h0};
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            left_reg  <= '0;
            mode_reg  <= MODE_DEC;
            upper_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            left_reg  <= left_next;
            mode_reg  <= mode_next;
            upper_reg <= upper_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        bin_reg  <= bin_next;
    end

    always_comb begin
        case (mode_reg)
            MODE_BIN: stat_o.digit = {3'b000, work_reg[39]};
            MODE_OCT: stat_o.digit = {1'b0, work_reg[39:37]};
            default:  stat_o.digit = work_reg[39:36];
        endcase
        stat_o.upper      = upper_reg;
        stat_o.last_digit = (left_reg == 6'd1);
        stat_o.last_step  = (step_reg == 6'd1);
    end

endmodule

`default_nettype wire

@@ sv/ife_emitter.sv @@
// Character emitter: running count, buffer position and stored flag, result register.
// Depends on ife_pkg for the emit request and result item structs.
`timescale 1ns / 1ps
`default_nettype none

module ife_emitter #(
    parameter int POSITION_BITS = ife_pkg::POSITION_BITS_DEFAULT
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire [ife_pkg::CAP_W-1:0]       capacity_i,
    input  ife_pkg::ife_emit_t             emit_i,
    output logic                           ready_o,
    output logic                           m_valid,
    input  wire                            m_ready,
    output ife_pkg::ife_out_t              m_item
);
    import ife_pkg::*;

    localparam int CMP_W = (POSITION_BITS > CAP_W) ? POSITION_BITS : CAP_W;
    localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic                     m_valid_reg;
    ife_out_t                 item_reg, item_next;
    logic                     fire;
    logic                     cap_nz;
    logic [CAP_W-1:0]         cap_m1;
    logic [CMP_W-1:0]         cnt_x, cap_x, pos_x;
    logic [POSITION_BITS-1:0] count_inc;

    assign ready_o = !m_valid_reg || m_ready;
    assign fire    = emit_i.valid && ready_o;
    assign cap_nz  = (capacity_i != '0);
    assign cap_m1  = capacity_i - CAP_W'(1);
    assign cnt_x   = CMP_W'(count_reg);
    assign cap_x   = CMP_W'(cap_m1);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg
                                                : count_reg + POSITION_BITS'(1);

    always_comb begin
        count_next         = count_reg;
        item_next.out_char = emit_i.ch;
        item_next.run_last = emit_i.last;
        if (emit_i.term) begin
            // terminator clamps to the last slot and is not counted
            pos_x  = (cap_nz && cnt_x > cap_x) ? cap_x : cnt_x;
            item_next.stored       = cap_nz;
            item_next.total_length = OUT_POS_W'(count_reg);
            count_next             = '0;
        end else begin
            pos_x  = cnt_x;
            item_next.stored       = cap_nz && (cnt_x < cap_x);
            item_next.total_length = OUT_POS_W'(count_inc);
            count_next             = count_inc;
        end
        item_next.out_position = OUT_POS_W'(pos_x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            item_reg <= item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = item_reg;

endmodule

`default_nettype wire

@@ sv/integer_format_engine.sv @@
// Integer format engine top level: item sequencer, capacity register, sub-units.
// Depends on ife_pkg, ife_digit_unit and ife_emitter.
//
// Usage: format-string characters arrive one per item on the s_ channel
// (valid/ready), each with a 32-bit argument word. Result items (one
// character each) leave on the m_ channel; run_last marks the final result
// of an input item. A '%' item alone gives no result. cfg_wr_en/cfg_wr_data
// write the buffer capacity (reset 256); the user must write it only while
// the block is idle, as the block itself does not enforce this. s_ready is
// high only while the sequencer is idle. Hex, octal and binary visit each
// digit position once, skipping leading zeros and emitting the rest.
// Decimal first runs 32 double-dabble steps in the shared BCD unit, then
// skips leading zeros and emits the rest of the 10 digit positions, with a
// minus sign first for a negative %d or %i value.
// The result register is refilled as it is taken; a stalled receiver holds
// the sequencer one result at a time. Synchronous reset clears the count,
// the pending '%', the sequencer and any result in flight.
`timescale 1ns / 1ps
`default_nettype none

module integer_format_engine #(
    parameter int POSITION_BITS = ife_pkg::POSITION_BITS_DEFAULT
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       cfg_wr_en,
    input  wire [ife_pkg::CAP_W-1:0]  cfg_wr_data,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  ife_pkg::ife_in_t          s_item,
    output logic                      m_valid,
    input  wire                       m_ready,
    output ife_pkg::ife_out_t         m_item
);
    import ife_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ONE    = 3'd1;
    localparam logic [2:0] S_MINUS  = 3'd2;
    localparam logic [2:0] S_DABBLE = 3'd3;
    localparam logic [2:0] S_SKIP   = 3'd4;
    localparam logic [2:0] S_DIGITS = 3'd5;
    localparam logic [2:0] S_BADEND = 3'd6;
    localparam logic [2:0] S_TERM   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic             pct_reg, pct_next;
    logic [7:0]       char_reg, char_next;
    logic [CAP_W-1:0] cap_reg;

    ife_dcmd_t  dcmd;
    ife_dstat_t dstat;
    ife_emit_t  emit;
    logic       emit_rdy;
    logic       accept;

    logic [7:0] ch;
    logic       is_signed, is_dec, is_numeric;
    logic [1:0] spec_mode;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign ch      = s_item.format_char;

    always_comb begin
        is_signed  = (ch == CH_LC_D) || (ch == CH_LC_I);
        is_dec     = is_signed || (ch == CH_LC_U);
        is_numeric = is_dec || (ch == CH_LC_B) || (ch == CH_LC_O)
                     || (ch == CH_LC_X) || (ch == CH_UC_X);
        if (is_dec) begin
            spec_mode = MODE_DEC;
        end else if (ch == CH_LC_B) begin
            spec_mode = MODE_BIN;
        end else if (ch == CH_LC_O) begin
            spec_mode = MODE_OCT;
        end else begin
            spec_mode = MODE_HEX;
        end
    end

    always_comb begin
        state_next = state_reg;
        pct_next   = pct_reg;
        char_next  = char_reg;
        dcmd.op    = OP_NONE;
        dcmd.mode  = spec_mode;
        dcmd.upper = (ch == CH_UC_X);
        dcmd.value = (is_signed && s_item.arg_value[31]) ? (32'd0 - s_item.arg_value)
                                                         : s_item.arg_value;
        emit.valid = 1'b0;
        emit.ch    = char_reg;
        emit.last  = 1'b1;
        emit.term  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_item.command) begin
                        pct_next   = 1'b0;
                        state_next = pct_reg ? S_BADEND : S_TERM;
                    end else if (!pct_reg) begin
                        if (ch == CHAR_PCT) begin
                            pct_next = 1'b1;
                        end else begin
                            char_next  = ch;
                            state_next = S_ONE;
                        end
                    end else begin
                        pct_next = 1'b0;
                        if (ch == CHAR_PCT) begin
                            char_next  = CHAR_PCT;
                            state_next = S_ONE;
                        end else if (!is_numeric) begin
                            char_next  = CHAR_BAD;
                            state_next = S_ONE;
                        end else if (s_item.arg_value == 32'd0) begin
                            char_next  = CHAR_ZERO;
                            state_next = S_ONE;
                        end else begin
                            dcmd.op = OP_LOAD;
                            if (is_signed && s_item.arg_value[31]) begin
                                state_next = S_MINUS;
                            end else if (is_dec) begin
                                state_next = S_DABBLE;
                            end else begin
                                state_next = S_SKIP;
                            end
                        end
                    end
                end
            end
            S_ONE: begin
                emit.valid = 1'b1;
                if (emit_rdy) begin
                    state_next = S_IDLE;
                end
            end
            S_MINUS: begin
                emit.valid = 1'b1;
                emit.ch    = CHAR_MINUS;
                emit.last  = 1'b0;
                if (emit_rdy) begin
                    state_next = S_DABBLE;
                end
            end
            S_DABBLE: begin
                dcmd.op = OP_DABBLE;
                if (dstat.last_step) begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zero digits; the value is known to be nonzero
                if (dstat.digit == 4'd0) begin
                    dcmd.op = OP_SHIFT;
                end else begin
                    state_next = S_DIGITS;
                end
            end
            S_DIGITS: begin
                emit.valid = 1'b1;
                emit.ch    = digit_char(dstat.digit, dstat.upper);
                emit.last  = dstat.last_digit;
                if (emit_rdy) begin
                    dcmd.op = OP_SHIFT;
                    if (dstat.last_digit) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_BADEND: begin
                emit.valid = 1'b1;
                emit.ch    = CHAR_BAD;
                emit.last  = 1'b0;
                if (emit_rdy) begin
                    state_next = S_TERM;
                end
            end
            S_TERM: begin
                emit.valid = 1'b1;
                emit.ch    = CHAR_NUL;
                emit.term  = 1'b1;
                if (emit_rdy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pct_reg   <= 1'b0;
            cap_reg   <= CAP_RESET;
        end else begin
            state_reg <= state_next;
            pct_reg   <= pct_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
    end

    ife_digit_unit u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_i   (dcmd),
        .stat_o  (dstat)
    );

    ife_emitter #(
        .POSITION_BITS (POSITION_BITS)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .capacity_i (cap_reg),
        .emit_i     (emit),
        .ready_o    (emit_rdy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    // double dabble runs to completion before digits are scanned
    a_dabble_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DABBLE |=> state_reg == S_DABBLE || state_reg == S_SKIP)
        else $error("dabble left early");

    // leading-zero skip never consumes the final digit
    a_skip_keeps_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SKIP && dstat.digit == 4'd0) |-> !dstat.last_digit)
        else $error("skip reached last digit");

    // end item always leaves no pending percent
    a_end_clears_pct: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.command) |=> !pct_reg)
        else $error("percent pending after end item");

    // nothing is offered to the emitter while a new item can be taken
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !emit.valid)
        else $error("emit request while idle");

endmodule

`default_nettype wire

@@ dv/ife_checker.sv @@
// Checker for the integer format engine: predicts every emitted character and compares.
// Watches the s_/m_ channels and the capacity write port; depends on ife_pkg.
`timescale 1ns / 1ps

module ife_checker (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_wr_en,
    input  wire [ife_pkg::CAP_W-1:0]   cfg_wr_data,
    input  wire                        s_valid,
    input  wire                        s_ready,
    input  ife_pkg::ife_in_t           s_item,
    input  wire                        m_valid,
    input  wire                        m_ready,
    input  ife_pkg::ife_out_t          m_item,
    output int                         mismatch_count,
    output int                         chars_outstanding
);
    import ife_pkg::*;

    localparam logic [OUT_POS_W-1:0] COUNT_MAX = '1;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_LC_A = 8'h61;

    logic [CAP_W-1:0]     capacity;
    logic                 pct_pending;
    logic [OUT_POS_W-1:0] char_count;
    ife_out_t             pending_chars[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] ife_checker: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic emit_char(input logic [7:0] ch);
        ife_out_t r;
        r.out_char     = ch;
        r.out_position = char_count;
        r.stored       = (capacity != '0) && (char_count < capacity - 1'b1);
        r.run_last     = 1'b0;
        if (char_count != COUNT_MAX) begin
            char_count++;
        end
        r.total_length = char_count;
        pending_chars.push_back(r);
    endtask

    task automatic expand_specifier(input logic [7:0] spec, input logic [31:0] value);
        logic [7:0]  digits [32];
        logic [31:0] v;
        logic [31:0] radix;
        logic [3:0]  d;
        int          n;
        v = value;
        n = 0;
        case (spec)
            CHAR_PCT: begin
                emit_char(CHAR_PCT);
            end
            CH_LC_D, CH_LC_I, CH_LC_U, CH_LC_B, CH_LC_O, CH_LC_X, CH_UC_X: begin
                if (v == '0) begin
                    emit_char(CHAR_ZERO);
                end else begin
                    case (spec)
                        CH_LC_B:          radix = 32'd2;
                        CH_LC_O:          radix = 32'd8;
                        CH_LC_X, CH_UC_X: radix = 32'd16;
                        default:          radix = 32'd10;
                    endcase
                    // magnitude wraps, so the signed minimum stays 0x80000000
                    if ((spec == CH_LC_D || spec == CH_LC_I) && v[31]) begin
                        emit_char(CHAR_MINUS);
                        v = 32'd0 - v;
                    end
                    while (v != '0) begin
                        d = 4'(v % radix);
                        if (d < 4'd10) begin
                            digits[n] = CHAR_ZERO + {4'b0000, d};
                        end else begin
                            digits[n] = (spec == CH_UC_X ? CHAR_UC_A : CHAR_LC_A)
                                        + {4'b0000, d} - 8'd10;
                        end
                        v = v / radix;
                        n++;
                    end
                    for (int i = n - 1; i >= 0; i--) begin
                        emit_char(digits[i]);
                    end
                end
            end
            default: begin
                emit_char(CHAR_BAD);
            end
        endcase
    endtask

    task automatic format_item(input ife_in_t it);
        ife_out_t nul;
        int       first;
        first = pending_chars.size();
        if (!it.command) begin
            if (pct_pending) begin
                pct_pending = 1'b0;
                expand_specifier(it.format_char, it.arg_value);
            end else if (it.format_char == CHAR_PCT) begin
                pct_pending = 1'b1;
            end else begin
                emit_char(it.format_char);
            end
        end else begin
            if (pct_pending) begin
                pct_pending = 1'b0;
                emit_char(CHAR_BAD);
            end
            // terminator is not counted; position clamps to the last buffer slot
            nul.out_char     = CHAR_NUL;
            nul.out_position = char_count;
            nul.stored       = 1'b0;
            nul.run_last     = 1'b0;
            nul.total_length = char_count;
            if (capacity != '0) begin
                nul.stored = 1'b1;
                if (char_count > capacity - 1'b1) begin
                    nul.out_position = capacity - 1'b1;
                end
            end
            pending_chars.push_back(nul);
            char_count = '0;
        end
        if (pending_chars.size() > first) begin
            pending_chars[pending_chars.size() - 1].run_last = 1'b1;
        end
    endtask

    task automatic check_char(input ife_out_t got);
        ife_out_t want;
        if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unpredicted item char %h position %0d",
                                      got.out_char, got.out_position));
        end else begin
            want = pending_chars.pop_front();
            if (got.out_char !== want.out_char) begin
                report_mismatch($sformatf("out_char %h, predicted %h (position %0d)",
                                          got.out_char, want.out_char, want.out_position));
            end
            if (got.out_position !== want.out_position) begin
                report_mismatch($sformatf("out_position %0d, predicted %0d",
                                          got.out_position, want.out_position));
            end
            if (got.stored !== want.stored) begin
                report_mismatch($sformatf("stored %b, predicted %b (position %0d)",
                                          got.stored, want.stored, want.out_position));
            end
            if (got.run_last !== want.run_last) begin
                report_mismatch($sformatf("run_last %b, predicted %b (position %0d)",
                                          got.run_last, want.run_last, want.out_position));
            end
            if (got.total_length !== want.total_length) begin
                report_mismatch($sformatf("total_length %0d, predicted %0d",
                                          got.total_length, want.total_length));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            capacity    = CAP_RESET;
            pct_pending = 1'b0;
            char_count  = '0;
            pending_chars.delete();
        end else begin
            if (cfg_wr_en) begin
                capacity = cfg_wr_data;
            end
            // predict before checking so a same-edge result finds its entry
            if (s_valid && s_ready) begin
                format_item(s_item);
            end
            if (m_valid && m_ready) begin
                check_char(m_item);
            end
        end
        chars_outstanding <= pending_chars.size();
    end

endmodule

@@ dv/tb_integer_format_engine.sv @@
// Testbench top for integer_format_engine: clock, reset, stimulus and verdict.
// Depends on ife_pkg, the block itself and ife_checker.
`timescale 1ns / 1ps

module tb_integer_format_engine;
    import ife_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 50;
    localparam logic [7:0] SPEC_CHARS [7] = '{CH_LC_D, CH_LC_I, CH_LC_U, CH_LC_B,
                                              CH_LC_O, CH_LC_X, CH_UC_X};

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    ife_in_t          s_item      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    ife_out_t         m_item;

    int   send_idle_pct    = 0;
    int   recv_idle_pct    = 0;
    int   hold_left        = 0;
    logic pressure_request = 1'b0;
    logic pressure_done    = 1'b0;
    int   items_sent       = 0;
    int   mismatch_count;
    int   chars_outstanding;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    integer_format_engine i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    ife_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_item            (s_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item            (m_item),
        .mismatch_count    (mismatch_count),
        .chars_outstanding (chars_outstanding)
    );

    // receiver: random back-pressure, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready       <= 1'b0;
            hold_left     <= 0;
            pressure_done <= 1'b0;
        end else if (pressure_request && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_ready       <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [31:0] arg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_item.command     <= cmd;
        s_item.format_char <= ch;
        s_item.arg_value   <= arg;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(1'b0, ch, $urandom());
    endtask

    task automatic send_spec(input logic [7:0] spec, input logic [31:0] arg);
        send_item(1'b0, CHAR_PCT, $urandom());
        send_item(1'b0, spec, arg);
    endtask

    task automatic end_string();
        send_item(1'b1, 8'($urandom_range(255)), $urandom());
    endtask

    // drain, then allow for a '%' item still in flight
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chars_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] random_argument();
        case ($urandom_range(5))
            0:       return '0;
            1:       return $urandom_range(15);
            2:       return 32'h8000_0000;
            3:       return '1;
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] random_capacity();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'd2;
            3:       return CAP_W'($urandom_range(40, 3));
            default: return CAP_W'($urandom_range(65535, 41));
        endcase
    endfunction

    // mostly well-formed conversions, with stray bytes and broken specifiers mixed in
    task automatic send_random_string();
        int tokens;
        int pick;
        tokens = $urandom_range(8, 1);
        repeat (tokens) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_spec(SPEC_CHARS[$urandom_range(6)], random_argument());
            end else if (pick < 67) begin
                send_spec(CHAR_PCT, $urandom());
            end else if (pick < 75) begin
                send_spec(8'($urandom_range(255)), random_argument());
            end else begin
                send_char(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(99) < 8) begin
            send_char(CHAR_PCT);
        end
        end_string();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset capacity, every conversion and the odd corners
        send_char(8'hFF);
        send_char(CHAR_NUL);
        send_spec(CH_LC_D, 32'd0);
        send_spec(CH_LC_D, 32'h8000_0000);
        send_spec(CH_LC_I, 32'hFFFF_FFFF);
        send_spec(CH_LC_U, 32'hFFFF_FFFF);
        send_spec(CH_LC_B, 32'hFFFF_FFFF);
        send_spec(CH_LC_O, 32'hFFFF_FFFF);
        send_spec(CH_LC_X, 32'hDEAD_BEEF);
        send_spec(CH_UC_X, 32'hABCD_EF09);
        send_spec(CH_UC_X, 32'd0);
        send_spec(CHAR_PCT, 32'd0);
        send_spec("q", 32'd5);
        send_spec(CHAR_NUL, 32'd7);
        end_string();
        send_char(CHAR_PCT);
        end_string();

        settle();
        write_capacity('0);
        send_char("a");
        send_spec(CH_LC_D, 32'd42);
        end_string();

        settle();
        write_capacity(16'd1);
        send_char("x");
        send_char("y");
        end_string();
        send_char(CHAR_PCT);
        end_string();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int target = items_sent + PHASE_ITEMS; items_sent < target; ) begin
                settle();
                write_capacity(random_capacity());
                if (phase == 2 && items_sent + PHASE_ITEMS == target) begin
                    pressure_request <= 1'b1;
                end
                repeat (3) send_random_string();
            end
        end

        // a short string into the largest buffer
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        write_capacity(16'hFFFF);
        send_spec(CH_LC_B, 32'hFFFF_FFFF);
        send_char("z");
        send_spec(CH_LC_D, 32'd12345);
        end_string();
        send_char("k");
        end_string();

        settle();
        if (mismatch_count == 0) begin
            $display("integer_format_engine verification clean");
        end else begin
            $display("integer_format_engine verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("integer_format_engine verification failed");
        $finish;
    end

endmodule
